/* sv/windowed_source_rssi_average_unit_defines.svh */
// Assertion macros shared by the checker of the windowed source RSSI average unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef WINDOWED_SOURCE_RSSI_AVERAGE_UNIT_DEFINES_SVH
`define WINDOWED_SOURCE_RSSI_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wsra_pkg.sv */
// Shared types, widths and constants of the windowed source RSSI average unit.
// Depends on nothing; imported by every module of the block but wsra_ram.
package wsra_pkg;

    localparam int DEPTH     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int SOURCE_W  = 8;
    localparam int INDEX_W   = 48;
    localparam int LEVEL_W   = 16;
    localparam int MEAN_W    = 16;
    localparam int USED_W    = 7;

    localparam int SUM_W     = LEVEL_W + PTR_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;
    localparam int ENTRY_W   = SOURCE_W + INDEX_W + LEVEL_W;

    localparam logic [INDEX_W-1:0] WINDOW_RESET = INDEX_W'(1000000);

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [INDEX_W-1:0]        sample_index;
        logic [SOURCE_W-1:0]       source;
    } entry_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MEAN_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* sv/windowed_source_rssi_average_unit.sv */
// Top level of the windowed source RSSI average unit: sequencer, frame ring, divider.
// Depends on wsra_pkg, wsra_ram and wsra_div.
//
// Each input beat on the s_ channel carries one frame: source, start sample index
// and a signed Q7.8 level. The frame is stored in a ring of DEPTH entries. The
// block then walks back from the newest frame through the ring, one stored frame
// per cycle through the RAM read port, adding the levels of same-source frames
// until it meets a same-source frame older than the window or has read every
// held frame. A bit-serial divider, one quotient bit per cycle, forms the mean,
// truncated toward zero. One output beat on the m_ channel carries the mean and
// the number of frames averaged. s_tready is high only between items. The user
// must write the window length through cfg_we and cfg_wdata only while the block
// is idle; the block itself does not enforce this. Reset clears the write
// pointer, the held count and the output valid, and loads the default window of
// one million samples; the ring contents stay as they are and are never read
// before they are written. A result waits in the output register while m_tready
// is low; the block still takes the next input beat and holds its own result back
// until the register is free.
module windowed_source_rssi_average_unit
    import wsra_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [INDEX_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // source[7:0], sample_index[55:8], level[71:56]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // mean_level[15:0], frames_used[22:16], zero[23]
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [INDEX_W-1:0]      window_reg, window_next;
    logic [PTR_W-1:0]        wp_reg, wp_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic [PTR_W-1:0]        newest_reg, newest_next;
    logic [SOURCE_W-1:0]     src_reg, src_next;
    logic [INDEX_W-1:0]      top_reg, top_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic                    start_reg, start_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    entry_t                  wr_entry;
    entry_t                  rd_entry;
    logic [ENTRY_W-1:0]      rd_data;
    logic [PTR_W-1:0]        rd_addr;
    logic [PTR_W:0]          rd_diff;
    logic                    accept;
    logic                    issuing;
    logic                    same_src;
    logic                    outside;
    logic                    finish;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign wr_entry.source       = s_tdata[SOURCE_W-1:0];
    assign wr_entry.sample_index = s_tdata[SOURCE_W+INDEX_W-1:SOURCE_W];
    assign wr_entry.level        = s_tdata[ENTRY_W-1:SOURCE_W+INDEX_W];

    assign rd_diff = {1'b0, newest_reg} - (PTR_W+1)'(issue_reg);
    assign rd_addr = rd_diff[PTR_W] ? PTR_W'(rd_diff + (PTR_W+1)'(DEPTH)) : rd_diff[PTR_W-1:0];

    wsra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = rd_data;
    assign issuing  = (state_reg == S_WALK) && (issue_reg != held_reg);
    assign same_src = (rd_entry.source == src_reg);
    assign outside  = (rd_entry.sample_index < top_reg) &&
                      ((top_reg - rd_entry.sample_index) > window_reg);
    assign finish   = pend_reg && ((same_src && outside) || !issuing);

    assign div_req.start    = start_reg;
    assign div_req.dividend = sum_reg;
    assign div_req.divisor  = used_reg;

    wsra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        window_next   = cfg_we ? cfg_wdata : window_reg;
        wp_next       = wp_reg;
        held_next     = held_reg;
        newest_next   = newest_reg;
        src_next      = src_reg;
        top_next      = top_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        sum_next      = sum_reg;
        used_next     = used_reg;
        start_next    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    newest_next = wp_reg;
                    wp_next     = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                    held_next   = (held_reg == CNT_W'(DEPTH)) ? held_reg : held_reg + CNT_W'(1);
                    src_next    = wr_entry.source;
                    top_next    = wr_entry.sample_index;
                    issue_next  = '0;
                    sum_next    = '0;
                    used_next   = '0;
                    state_next  = S_WALK;
                end
            end
            S_WALK: begin
                if (pend_reg && same_src && !outside) begin
                    sum_next  = sum_reg + SUM_W'(rd_entry.level);
                    used_next = used_reg + CNT_W'(1);
                end
                if (finish) begin
                    start_next = 1'b1;
                    state_next = S_DIV;
                end else begin
                    pend_next  = issuing;
                    issue_next = issue_reg + CNT_W'(issuing);
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({USED_W'(used_reg), div_rsp.quotient});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            window_reg   <= WINDOW_RESET;
            wp_reg       <= '0;
            held_reg     <= '0;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            wp_reg       <= wp_next;
            held_reg     <= held_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        newest_reg  <= newest_next;
        src_reg     <= src_next;
        top_reg     <= top_next;
        sum_reg     <= sum_next;
        used_reg    <= used_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* sv/wsra_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the ring of stored frames.
module wsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/wsra_div.sv */
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on wsra_pkg for widths and the request and response structs.
module wsra_div
    import wsra_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     divisor_reg;

    logic [CNT_W:0]       shifted;
    logic                 fits;
    logic [SUM_W-1:0]     magnitude;
    logic [SUM_W-1:0]     signed_quo;

    assign magnitude  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
    assign shifted    = {rem_reg, quo_reg[SUM_W-1]};
    assign fits       = shifted >= {1'b0, divisor_reg};
    assign signed_quo = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg    <= 1'b1;
                cnt_reg     <= DIV_CNT_W'(SUM_W);
                quo_reg     <= magnitude;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
                neg_reg     <= req.dividend[SUM_W-1];
            end else if (busy_reg) begin
                rem_reg <= fits ? CNT_W'(shifted - {1'b0, divisor_reg}) : shifted[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], fits};
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = signed_quo[MEAN_W-1:0];

endmodule

/* sv/wsra_checker.sv */
// Port-level checker of the windowed source RSSI average unit, bound to the top level.
// Depends on wsra_pkg and windowed_source_rssi_average_unit_defines.svh.
`include "windowed_source_rssi_average_unit_defines.svh"

module wsra_checker
    import wsra_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `WSRA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Output beat changed while stalled.")
    `WSRA_ASSERT_NOW(a_used_range, aclk, aresetn, m_tvalid, (m_tdata[22:16] != 7'd0) && (m_tdata[22:16] <= USED_W'(DEPTH)), "Frame count of an output beat is out of range.")
    `WSRA_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[23] == 1'b0, "Padding bit of an output beat is set.")
    `WSRA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "Input taken again right after an input beat.")

endmodule

bind windowed_source_rssi_average_unit wsra_checker u_wsra_checker (.*);

/* tb/testbench.sv */
// Testbench of windowed_source_rssi_average_unit: random and directed frames with a
// built-in predictor of the per-source windowed mean, checked beat by beat.
// Depends on wsra_pkg and the unit's RTL only.
module testbench
    import wsra_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int PHASE_FRAMES   = 100;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    typedef enum {STEP_FRAME, STEP_WINDOW, STEP_HOLD, STEP_DRAIN} step_kind_t;
    typedef enum {LEVEL_ANY, LEVEL_LOW, LEVEL_HIGH, LEVEL_EXTREME} level_mode_t;

    typedef struct {
        step_kind_t                kind;
        logic [SOURCE_W-1:0]       source;
        logic [INDEX_W-1:0]        sample_index;
        logic signed [LEVEL_W-1:0] level;
        logic [INDEX_W-1:0]        window;
    } plan_step_t;

    typedef struct {
        logic signed [MEAN_W-1:0] mean;
        logic [USED_W-1:0]        used;
    } mean_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [INDEX_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    plan_step_t   plan[$];
    mean_result_t pending_means[$];

    logic [SOURCE_W-1:0]       ring_source [DEPTH];
    logic [INDEX_W-1:0]        ring_index [DEPTH];
    logic signed [LEVEL_W-1:0] ring_level [DEPTH];
    int                        ring_wr = 0;
    int                        ring_held = 0;
    logic [INDEX_W-1:0]        window_len = WINDOW_RESET;

    bit frame_taken = 1'b0;
    bit result_taken = 1'b0;
    bit plan_finished = 1'b0;
    int hold_ticket = 0;
    int holds_served = 0;
    int hold_left = 0;
    int send_gap = 0;
    int sender_calm = 0;
    int take_gap = 0;
    int receiver_calm = 0;
    int settle_left = SETTLE_CYCLES;
    int quiet_cycles = 0;

    int frames_sent = 0;
    int windows_written = 0;
    int means_checked = 0;
    int deepest = 0;
    int full_ring_means = 0;
    int mismatches = 0;

    bit                       valid_next;
    bit                       we_next;
    plan_step_t               current;
    mean_result_t             want;
    logic signed [MEAN_W-1:0] got_mean;
    logic [USED_W-1:0]        got_used;

    windowed_source_rssi_average_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 96) return $urandom_range(5, 20);
        return $urandom_range(30, 120);
    endfunction

    // Stores the frame in the ring, then averages the same-source frames back to the first one older than the window.
    function automatic mean_result_t windowed_mean(input logic [SOURCE_W-1:0] src,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic signed [LEVEL_W-1:0] lvl);
        mean_result_t res;
        longint       sum;
        longint       quotient;
        int           used;
        int           newest;
        int           pos;
        int           k;
        bit           stop;
        newest = ring_wr;
        ring_source[newest] = src;
        ring_index[newest] = idx;
        ring_level[newest] = lvl;
        ring_wr = (ring_wr + 1) % DEPTH;
        if (ring_held < DEPTH) ring_held++;
        sum = 0;
        used = 0;
        stop = 1'b0;
        for (k = 0; k < ring_held && !stop; k++) begin
            pos = (newest + DEPTH - k) % DEPTH;
            if (ring_source[pos] == src) begin
                if (ring_index[pos] < idx && (idx - ring_index[pos]) > window_len) begin
                    stop = 1'b1;
                end else begin
                    sum = sum + longint'(ring_level[pos]);
                    used++;
                end
            end
        end
        quotient = sum / longint'(used);
        res.mean = quotient[MEAN_W-1:0];
        res.used = used[USED_W-1:0];
        return res;
    endfunction

    task automatic note_mismatch(input string what);
        $display("tb: mismatch at %0t: %0s", $realtime, what);
        mismatches++;
    endtask

    task automatic add_frame(input logic [SOURCE_W-1:0] src, input logic [INDEX_W-1:0] idx,
                             input logic signed [LEVEL_W-1:0] lvl);
        plan_step_t st;
        st.kind = STEP_FRAME;
        st.source = src;
        st.sample_index = idx;
        st.level = lvl;
        st.window = '0;
        plan.push_back(st);
    endtask

    task automatic add_control(input step_kind_t kind, input logic [INDEX_W-1:0] win);
        plan_step_t st;
        st.kind = kind;
        st.source = '0;
        st.sample_index = '0;
        st.level = '0;
        st.window = win;
        plan.push_back(st);
    endtask

    function automatic logic signed [LEVEL_W-1:0] level_for(input level_mode_t mode);
        logic [LEVEL_W-1:0] raw;
        raw = LEVEL_W'($urandom);
        case (mode)
            LEVEL_LOW:     return -16'sd32768;
            LEVEL_HIGH:    return 16'sd32767;
            LEVEL_EXTREME: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            default: begin
                if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                return raw;
            end
        endcase
    endfunction

    // Well-formed runs of a few sources with rising indices, sprinkled with noise frames (in LEVEL_ANY
    // mode only) and an occasional step back in index.
    task automatic add_random_phase(input logic [INDEX_W-1:0] win, input int nsrc,
                                    input level_mode_t mode, input bit with_hold);
        logic [SOURCE_W-1:0] sources [4];
        logic [INDEX_W-1:0]  idx;
        logic [63:0]         wide;
        logic [63:0]         cap;
        logic [63:0]         step;
        logic [SOURCE_W-1:0] noise_src;
        logic [LEVEL_W-1:0]  noise_lvl;
        int                  noise;
        int                  r;
        int                  n;
        add_control(STEP_WINDOW, win);
        if (nsrc == 0) nsrc = $urandom_range(1, 4);
        for (n = 0; n < 4; n++) sources[n] = SOURCE_W'($urandom);
        wide = {$urandom, $urandom};
        idx = wide[INDEX_W-1:0];
        if (win == 0) cap = 1;
        else if (win == INDEX_MAX) cap = 64'hFFFF_FFFF;
        else cap = 64'(win) / 8 + 1;
        noise = (mode == LEVEL_ANY) ? 15 : 0;
        for (n = 0; n < PHASE_FRAMES; n++) begin
            if (with_hold && n == 20) add_control(STEP_HOLD, '0);
            r = $urandom_range(0, 99);
            if (r < noise) begin
                noise_src = SOURCE_W'($urandom);
                noise_lvl = LEVEL_W'($urandom);
                wide = {$urandom, $urandom};
                add_frame(noise_src, wide[INDEX_W-1:0], noise_lvl);
            end else begin
                wide = {$urandom, $urandom};
                step = wide % (cap + 1);
                if (r < noise + 3) idx = idx - step[INDEX_W-1:0];
                else idx = idx + step[INDEX_W-1:0];
                add_frame(sources[$urandom_range(0, nsrc - 1)], idx, level_for(mode));
            end
        end
        add_control(STEP_DRAIN, '0);
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            valid_next = s_tvalid && !frame_taken;
            we_next = 1'b0;
            if (frame_taken) begin
                if (sender_calm > 0) begin
                    sender_calm--;
                    send_gap = 0;
                end else begin
                    send_gap = pause_length();
                    if ($urandom_range(0, 29) == 0) sender_calm = $urandom_range(5, 20);
                end
            end
            if (!valid_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (plan.size() == 0) begin
                    plan_finished = 1'b1;
                end else begin
                    case (plan[0].kind)
                        STEP_FRAME: begin
                            current = plan.pop_front();
                            s_tdata <= {current.level, current.sample_index, current.source};
                            valid_next = 1'b1;
                        end
                        STEP_WINDOW: begin
                            current = plan.pop_front();
                            cfg_wdata <= current.window;
                            we_next = 1'b1;
                            windows_written++;
                        end
                        STEP_HOLD: begin
                            current = plan.pop_front();
                            hold_ticket <= hold_ticket + 1;
                        end
                        STEP_DRAIN: begin
                            if (pending_means.size() != 0) begin
                                settle_left = SETTLE_CYCLES;
                            end else if (settle_left > 0) begin
                                settle_left--;
                            end else begin
                                settle_left = SETTLE_CYCLES;
                                current = plan.pop_front();
                            end
                        end
                    endcase
                end
            end
            s_tvalid <= valid_next;
            cfg_we <= we_next;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_ticket != holds_served) begin
                holds_served = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (receiver_calm > 0) receiver_calm--;
            else if ($urandom_range(0, 499) == 0) receiver_calm = $urandom_range(200, 1500);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (take_gap == 0 && receiver_calm == 0 && $urandom_range(0, 9) == 0) begin
                    take_gap = pause_length();
                end
                if (take_gap > 0) begin
                    take_gap--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            frame_taken = 1'b0;
            result_taken = 1'b0;
            window_len = WINDOW_RESET;
            ring_wr = 0;
            ring_held = 0;
        end else begin
            frame_taken = s_tvalid && s_tready;
            result_taken = m_tvalid && m_tready;
            if (cfg_we) window_len = cfg_wdata;
            if (frame_taken) begin
                pending_means.push_back(windowed_mean(s_tdata[SOURCE_W-1:0],
                                                      s_tdata[SOURCE_W+INDEX_W-1:SOURCE_W],
                                                      s_tdata[ENTRY_W-1:SOURCE_W+INDEX_W]));
                frames_sent++;
            end
            if (result_taken) begin
                got_mean = m_tdata[MEAN_W-1:0];
                got_used = m_tdata[MEAN_W+USED_W-1:MEAN_W];
                if (pending_means.size() == 0) begin
                    note_mismatch($sformatf("result beat with nothing expected, tdata %h", m_tdata));
                end else begin
                    want = pending_means.pop_front();
                    if (got_mean !== want.mean) begin
                        note_mismatch($sformatf("mean_level %0d, expected %0d", got_mean, want.mean));
                    end
                    if (got_used !== want.used) begin
                        note_mismatch($sformatf("frames_used %0d, expected %0d", got_used, want.used));
                    end
                    means_checked++;
                    if (int'(want.used) > deepest) deepest = int'(want.used);
                    if (int'(want.used) == DEPTH) full_ring_means++;
                end
            end
        end
        if (frame_taken || result_taken || cfg_we || !aresetn) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: stalled for %0d cycles with %0d results outstanding",
                     quiet_cycles, pending_means.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // Reset window: extremes, the exact window edge, one sample past it, an index
        // behind the newest frame, and truncation of a negative mean.
        add_frame(8'h00, 48'd0, 16'sd32767);
        add_frame(8'h00, 48'd0, -16'sd32768);
        add_frame(8'hFF, INDEX_MAX, -16'sd32768);
        add_frame(8'h00, 48'd1000000, 16'sd100);
        add_frame(8'h00, 48'd1000001, -16'sd1);
        add_frame(8'h00, 48'd500, 16'sd7);
        add_frame(8'hFF, 48'd0, 16'sd1);
        add_frame(8'h07, 48'd10, -16'sd3);
        add_frame(8'h07, 48'd11, -16'sd4);
        add_frame(8'hA5, 48'h5A5A_5A5A_5A5A, 16'sh5555);
        add_frame(8'h5A, 48'hA5A5_A5A5_A5A5, 16'shAAAA);
        add_control(STEP_DRAIN, '0);
        add_control(STEP_WINDOW, '0);
        add_frame(8'h03, 48'd100, 16'sd10);
        add_frame(8'h03, 48'd100, 16'sd20);
        add_frame(8'h03, 48'd101, 16'sd30);
        add_frame(8'h03, 48'd99, -16'sd5);
        add_control(STEP_DRAIN, '0);
        add_control(STEP_WINDOW, INDEX_MAX);
        add_frame(8'h09, 48'd0, -16'sd32768);
        add_frame(8'h09, INDEX_MAX, 16'sd32767);
        add_frame(8'h09, 48'd0, 16'sd5);
        add_frame(8'h80, 48'd1234, -16'sd100);
        add_control(STEP_DRAIN, '0);

        add_random_phase(INDEX_MAX, 1, LEVEL_LOW, 1'b0);
        add_random_phase(INDEX_MAX, 1, LEVEL_HIGH, 1'b1);
        add_random_phase('0, 0, LEVEL_ANY, 1'b0);
        add_random_phase(INDEX_W'($urandom_range(1, 16)), 0, LEVEL_ANY, 1'b1);
        add_random_phase(INDEX_W'($urandom_range(16, 4000)), 0, LEVEL_ANY, 1'b0);
        add_random_phase(INDEX_W'($urandom_range(4096, 1 << 30)), 0, LEVEL_ANY, 1'b0);
        add_random_phase(INDEX_W'({$urandom, $urandom}), 0, LEVEL_ANY, 1'b0);
        add_random_phase(INDEX_MAX, 0, LEVEL_EXTREME, 1'b1);
        add_random_phase(INDEX_W'(1000000), 0, LEVEL_ANY, 1'b0);

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        wait (plan_finished);
        if (pending_means.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", pending_means.size()));
        end
        $display("tb: %0d frames sent under %0d window writes, %0d means compared",
                 frames_sent, windows_written, means_checked);
        $display("tb: widest average took %0d frames, %0d means over a full ring, %0d mismatches",
                 deepest, full_ring_means, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* windowed_source_rssi_average_unit.f */
+incdir+sv
sv/wsra_pkg.sv
sv/wsra_ram.sv
sv/wsra_div.sv
sv/windowed_source_rssi_average_unit.sv
sv/wsra_checker.sv
tb/testbench.sv
